// ----- design/dosp_pkg.sv -----
`timescale 1ns / 1ps

package dosp_pkg;

    // Result record kinds
    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Summary status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [1:0] STATUS_HOST_LONG = 2'd3;

    // Configuration register indexes
    localparam logic REG_HOSTNAME_MAX = 1'b0;
    localparam logic REG_VENDOR_MAX   = 1'b1;

    // Result queue sizing
    localparam int FifoDepth = 4;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CntW      = $clog2(FifoDepth + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic        record_kind;
        logic [7:0]  option_code;
        logic [7:0]  value_byte;
        logic [7:0]  value_index;
        logic [47:0] client_mac;
        logic [31:0] offered_ip;
        logic [7:0]  message_type;
        logic [31:0] lease_seconds;
        logic        lease_present;
        logic [1:0]  packet_status;
        logic        run_end;
    } out_beat_t;

    // Records produced by one accepted byte: zero, one or two.
    typedef struct packed {
        logic [1:0] count;
        out_beat_t  first;
        out_beat_t  second;
    } push_t;

endpackage

// ----- design/dosp_parser.sv -----
`timescale 1ns / 1ps

module dosp_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  dosp_pkg::in_beat_t in_beat,
    input  logic [7:0]        hostname_max_len,
    input  logic [7:0]        vendor_max_len,
    output dosp_pkg::push_t   push
);
    import dosp_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CODE   = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_VALUE  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_HOSTNAME = 8'd12;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_MSGTYPE  = 8'd53;
    localparam logic [7:0] OPT_PARAMS   = 8'd55;
    localparam logic [7:0] OPT_VENDOR   = 8'd60;
    localparam logic [7:0] OPT_SEARCH   = 8'd119;
    localparam logic [7:0] OPT_END      = 8'd255;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h63;
            2'd1:    v = 8'h82;
            2'd2:    v = 8'h53;
            default: v = 8'h63;
        endcase
        return v;
    endfunction

    logic [7:0]  byte_position_reg,  byte_position_next;
    logic [2:0]  parse_phase_reg,    parse_phase_next;
    logic [7:0]  current_code_reg,   current_code_next;
    logic [7:0]  bytes_left_reg,     bytes_left_next;
    logic [7:0]  byte_in_option_reg, byte_in_option_next;
    logic        emit_current_reg,   emit_current_next;
    logic [47:0] mac_store_reg,      mac_store_next;
    logic [31:0] ip_store_reg,       ip_store_next;
    logic [7:0]  type_store_reg,     type_store_next;
    logic [31:0] lease_store_reg,    lease_store_next;
    logic [31:0] lease_shift_reg,    lease_shift_next;
    logic        lease_flag_reg,     lease_flag_next;
    logic [1:0]  status_store_reg,   status_store_next;

    always_comb
    begin
        logic [7:0] b;
        logic [7:0] p;
        logic       val_emit;
        out_beat_t  val_rec;
        out_beat_t  sum_rec;

        b = in_beat.data_byte;
        p = byte_position_reg;
        val_emit = 1'b0;

        byte_position_next  = byte_position_reg;
        parse_phase_next    = parse_phase_reg;
        current_code_next   = current_code_reg;
        bytes_left_next     = bytes_left_reg;
        byte_in_option_next = byte_in_option_reg;
        emit_current_next   = emit_current_reg;
        mac_store_next      = mac_store_reg;
        ip_store_next       = ip_store_reg;
        type_store_next     = type_store_reg;
        lease_store_next    = lease_store_reg;
        lease_shift_next    = lease_shift_reg;
        lease_flag_next     = lease_flag_reg;
        status_store_next   = status_store_reg;

        unique case (parse_phase_reg)
            PH_HEADER:
            begin
                byte_position_next = 8'(p + 8'd1);
                if (p >= 8'd16 && p <= 8'd19)
                begin
                    ip_store_next = {ip_store_reg[23:0], b};
                end
                else if (p >= 8'd28 && p <= 8'd33)
                begin
                    mac_store_next = {mac_store_reg[39:0], b};
                end
                else if (p >= 8'd236)
                begin
                    if (b != cookie_byte(p[1:0]))
                    begin
                        status_store_next  = STATUS_BAD_MAGIC;
                        parse_phase_next   = PH_DONE;
                        byte_position_next = p;
                    end
                    else if (p == 8'd239)
                    begin
                        parse_phase_next   = PH_CODE;
                        byte_position_next = p;
                    end
                end
            end
            PH_CODE:
            begin
                if (b == OPT_END)
                begin
                    parse_phase_next = PH_DONE;
                end
                else if (b != OPT_PAD)
                begin
                    current_code_next = b;
                    parse_phase_next  = PH_LEN;
                end
            end
            PH_LEN:
            begin
                bytes_left_next     = b;
                byte_in_option_next = 8'd0;
                lease_shift_next    = 32'd0;
                if (current_code_reg == OPT_HOSTNAME && b > hostname_max_len)
                begin
                    status_store_next = STATUS_HOST_LONG;
                    parse_phase_next  = PH_DONE;
                end
                else
                begin
                    emit_current_next = (current_code_reg == OPT_PARAMS)
                        || (current_code_reg == OPT_SEARCH)
                        || (current_code_reg == OPT_HOSTNAME && b != 8'd0)
                        || (current_code_reg == OPT_VENDOR && b != 8'd0
                            && b <= vendor_max_len);
                    parse_phase_next = (b == 8'd0) ? PH_CODE : PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (current_code_reg == OPT_MSGTYPE && byte_in_option_reg == 8'd0)
                begin
                    lease_shift_next = {24'd0, b};
                end
                if (current_code_reg == OPT_LEASE && byte_in_option_reg < 8'd4)
                begin
                    lease_shift_next = {lease_shift_reg[23:0], b};
                end
                val_emit = emit_current_reg &&
                           (current_code_reg != OPT_PARAMS || b != 8'd0);
                byte_in_option_next = 8'(byte_in_option_reg + 8'd1);
                bytes_left_next     = 8'(bytes_left_reg - 8'd1);
                if (bytes_left_next == 8'd0)
                begin
                    if (current_code_reg == OPT_MSGTYPE)
                    begin
                        type_store_next = lease_shift_next[7:0];
                    end
                    if (current_code_reg == OPT_LEASE && byte_in_option_next >= 8'd4)
                    begin
                        lease_store_next = lease_shift_next;
                        lease_flag_next  = 1'b1;
                    end
                    lease_shift_next  = 32'd0;
                    emit_current_next = 1'b0;
                    parse_phase_next  = PH_CODE;
                end
            end
            default:
            begin
            end
        endcase

        // Packet closes: truncation check, then summary from updated stores
        if (in_beat.last_byte && (parse_phase_next == PH_HEADER ||
            parse_phase_next == PH_LEN || parse_phase_next == PH_VALUE))
        begin
            status_store_next = STATUS_TRUNCATED;
        end

        val_rec             = '0;
        val_rec.record_kind = KIND_VALUE;
        val_rec.option_code = current_code_reg;
        val_rec.value_byte  = b;
        val_rec.value_index = byte_in_option_reg;
        val_rec.run_end     = !in_beat.last_byte;

        sum_rec               = '0;
        sum_rec.record_kind   = KIND_SUMMARY;
        sum_rec.client_mac    = mac_store_next;
        sum_rec.offered_ip    = ip_store_next;
        sum_rec.message_type  = type_store_next;
        sum_rec.lease_seconds = lease_store_next;
        sum_rec.lease_present = lease_flag_next;
        sum_rec.packet_status = status_store_next;
        sum_rec.run_end       = 1'b1;

        push.first  = val_emit ? val_rec : sum_rec;
        push.second = sum_rec;
        push.count  = accept ? (2'({1'b0, val_emit}) + 2'({1'b0, in_beat.last_byte}))
                             : 2'd0;

        if (in_beat.last_byte)
        begin
            byte_position_next  = 8'd0;
            parse_phase_next    = PH_HEADER;
            current_code_next   = 8'd0;
            bytes_left_next     = 8'd0;
            byte_in_option_next = 8'd0;
            emit_current_next   = 1'b0;
            mac_store_next      = 48'd0;
            ip_store_next       = 32'd0;
            type_store_next     = 8'd0;
            lease_store_next    = 32'd0;
            lease_shift_next    = 32'd0;
            lease_flag_next     = 1'b0;
            status_store_next   = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg  <= 8'd0;
            parse_phase_reg    <= PH_HEADER;
            current_code_reg   <= 8'd0;
            bytes_left_reg     <= 8'd0;
            byte_in_option_reg <= 8'd0;
            emit_current_reg   <= 1'b0;
            mac_store_reg      <= 48'd0;
            ip_store_reg       <= 32'd0;
            type_store_reg     <= 8'd0;
            lease_store_reg    <= 32'd0;
            lease_shift_reg    <= 32'd0;
            lease_flag_reg     <= 1'b0;
            status_store_reg   <= STATUS_OK;
        end
        else if (accept)
        begin
            byte_position_reg  <= byte_position_next;
            parse_phase_reg    <= parse_phase_next;
            current_code_reg   <= current_code_next;
            bytes_left_reg     <= bytes_left_next;
            byte_in_option_reg <= byte_in_option_next;
            emit_current_reg   <= emit_current_next;
            mac_store_reg      <= mac_store_next;
            ip_store_reg       <= ip_store_next;
            type_store_reg     <= type_store_next;
            lease_store_reg    <= lease_store_next;
            lease_shift_reg    <= lease_shift_next;
            lease_flag_reg     <= lease_flag_next;
            status_store_reg   <= status_store_next;
        end
    end

    // Closing byte returns the packet state to its cleared form
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_beat.last_byte |=> parse_phase_reg == PH_HEADER
            && byte_position_reg == 8'd0 && status_store_reg == STATUS_OK)
        else $error("packet state not cleared after last byte");

    // Position freezes inside the cookie once the header is left
    a_position_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        parse_phase_reg != PH_HEADER |-> byte_position_reg >= 8'd236
            && byte_position_reg <= 8'd239)
        else $error("byte position outside cookie after header");

endmodule

// ----- design/dosp_out_fifo.sv -----
`timescale 1ns / 1ps

module dosp_out_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  dosp_pkg::push_t     push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_stall,
    output dosp_pkg::out_beat_t out_data
);
    import dosp_pkg::*;

    out_beat_t         entry_reg [FifoDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg,  count_next;
    logic              pop;

    // Two free slots are needed since one byte may raise two records
    assign room      = count_reg <= CntW'(FifoDepth - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = PtrW'(wr_ptr_reg + PtrW'(push.count));
        rd_ptr_next = pop ? PtrW'(rd_ptr_reg + PtrW'(1)) : rd_ptr_reg;
        count_next  = CntW'(count_reg + CntW'(push.count) - CntW'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[PtrW'(wr_ptr_reg + PtrW'(1))] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> CntW'(count_reg + CntW'(push.count)) <= CntW'(FifoDepth))
        else $error("result queue overflow");

    a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != CntW'(FifoDepth) |->
            PtrW'(wr_ptr_reg - rd_ptr_reg) == PtrW'(count_reg))
        else $error("queue count disagrees with pointers");

endmodule

// ----- design/dhcp_option_stream_parser.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      in_valid / in_stall       in_data   (in_beat_t: data_byte, last_byte)
// out      output     out_valid / out_stall     out_data  (out_beat_t: one record per beat)
// cfg      input      cfg_we (no wait)          cfg_index, cfg_wdata
//
// One payload byte is taken per cycle while in_stall is low; parse state is updated
// at the accept edge. A byte raises zero, one or two records (value byte, then summary
// on last_byte), written together into a 4-entry result queue that drives out_data
// directly. in_stall rises whenever fewer than two queue slots are free; a record is
// written into the queue at the edge that accepts its byte. Reset clears parse state
// and restores both length limits to 62; the byte that raises the summary returns the
// packet state to reset.

module dhcp_option_stream_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dosp_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output dosp_pkg::out_beat_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata
);
    import dosp_pkg::*;

    logic [7:0] hostname_max_len_reg;
    logic [7:0] vendor_max_len_reg;
    logic       room;
    logic       accept;
    push_t      push;

    assign in_stall = !room;
    assign accept   = in_valid && room;

    // Length limits; user writes them only while the parser is idle; block does not check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hostname_max_len_reg <= 8'd62;
            vendor_max_len_reg   <= 8'd62;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HOSTNAME_MAX: hostname_max_len_reg <= cfg_wdata;
                REG_VENDOR_MAX:   vendor_max_len_reg   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    dosp_parser u_parser
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .in_beat          (in_data),
        .hostname_max_len (hostname_max_len_reg),
        .vendor_max_len   (vendor_max_len_reg),
        .push             (push)
    );

    dosp_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import dosp_pkg::*;

    // DHCP option codes the parser cares about
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_HOSTNAME = 8'd12;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_PARAMS   = 8'd55;
    localparam logic [7:0] OPT_VENDOR   = 8'd60;
    localparam logic [7:0] OPT_SEARCH   = 8'd119;
    localparam logic [7:0] OPT_END      = 8'd255;

    localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
    localparam int          HDR_LEN      = 236;   // fixed header, cookie follows
    localparam int          SETTLE       = 4;     // threshold of settle_cnt for a pause step
    localparam int          ITEM_BUDGET  = 1550;  // payload beats over the whole run

    typedef enum logic [2:0] {PH_HEADER, PH_CODE, PH_LEN, PH_VALUE, PH_DONE} parse_phase_t;
    typedef enum logic [1:0] {ACT_BYTE, ACT_HOLD, ACT_CFG} act_t;

    // One step of the sender's plan: a payload beat, a pause until the
    // parser has drained, or a register write.
    typedef struct packed {
        act_t       kind;
        in_beat_t   beat;
        logic       idx;
        logic [7:0] val;
    } plan_item_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;
    logic      cfg_we    = 1'b0;
    logic      cfg_index = REG_HOSTNAME_MAX;
    logic [7:0] cfg_wdata = 8'd0;

    plan_item_t  plan[$];
    out_beat_t   records_due[$];
    logic [7:0]  pkt[$];
    int          fail_count   = 0;
    int          cyc          = 0;
    int          settle_cnt   = 0;
    int          sent_bytes   = 0;
    logic        quiet;

    // Limits as the generator believes them, used to aim lengths at the edges
    logic [7:0]  gen_host = 8'd62;
    logic [7:0]  gen_vend = 8'd62;

    // Parser image: packet state plus the two length limits
    logic [7:0]   p_pos    = '0;
    parse_phase_t p_phase  = PH_HEADER;
    logic [7:0]   p_code   = '0;
    logic [7:0]   p_left   = '0;
    logic [7:0]   p_idx    = '0;
    logic         p_emit   = 1'b0;
    logic [47:0]  p_mac    = '0;
    logic [31:0]  p_ip     = '0;
    logic [7:0]   p_type   = '0;
    logic [31:0]  p_lease  = '0;
    logic [31:0]  p_shift  = '0;
    logic         p_lflag  = 1'b0;
    logic [1:0]   p_status = STATUS_OK;
    logic [7:0]   lim_host = 8'd62;
    logic [7:0]   lim_vend = 8'd62;

    dhcp_option_stream_parser DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // No random idling on either side during this window
    assign quiet = (cyc >= 300) && (cyc < 900);

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    // ------------------------------------------------------------------
    // Parser image
    // ------------------------------------------------------------------

    task automatic clear_parse();
        p_pos    = '0;
        p_phase  = PH_HEADER;
        p_code   = '0;
        p_left   = '0;
        p_idx    = '0;
        p_emit   = 1'b0;
        p_mac    = '0;
        p_ip     = '0;
        p_type   = '0;
        p_lease  = '0;
        p_shift  = '0;
        p_lflag  = 1'b0;
        p_status = STATUS_OK;
    endtask

    task automatic set_limit(input logic idx, input logic [7:0] val);
        if (idx == REG_HOSTNAME_MAX)
            lim_host = val;
        else
            lim_vend = val;
    endtask

    // Advance the image by one accepted byte and queue the records it raises.
    task automatic parse_byte(input in_beat_t beat);
        out_beat_t  val_rec;
        out_beat_t  sum_rec;
        logic       have_val;
        logic [7:0] b;
        b        = beat.data_byte;
        have_val = 1'b0;
        val_rec  = '0;
        case (p_phase)
            PH_HEADER:
            begin
                if (p_pos >= 8'd16 && p_pos <= 8'd19)
                    p_ip = {p_ip[23:0], b};
                else if (p_pos >= 8'd28 && p_pos <= 8'd33)
                    p_mac = {p_mac[39:0], b};
                // cookie occupies 236..239; 236 is a multiple of 4
                if (p_pos >= 8'd236 && b != MAGIC_COOKIE[8 * (3 - p_pos[1:0]) +: 8])
                begin
                    p_status = STATUS_BAD_MAGIC;
                    p_phase  = PH_DONE;
                end
                else if (p_pos == 8'd239)
                    p_phase = PH_CODE;
                else
                    p_pos = p_pos + 8'd1;
            end
            PH_CODE:
            begin
                if (b == OPT_END)
                    p_phase = PH_DONE;
                else if (b != OPT_PAD)
                begin
                    p_code  = b;
                    p_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                p_left  = b;
                p_idx   = '0;
                p_shift = '0;
                if (p_code == OPT_HOSTNAME && b > lim_host)
                begin
                    p_status = STATUS_HOST_LONG;
                    p_phase  = PH_DONE;
                end
                else
                begin
                    p_emit = (p_code == OPT_PARAMS) || (p_code == OPT_SEARCH) ||
                             (p_code == OPT_HOSTNAME && b != 8'd0) ||
                             (p_code == OPT_VENDOR && b != 8'd0 && b <= lim_vend);
                    p_phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (p_code == OPT_MSG_TYPE && p_idx == 8'd0)
                    p_shift = {24'd0, b};
                if (p_code == OPT_LEASE && p_idx < 8'd4)
                    p_shift = {p_shift[23:0], b};
                // parameter list drops zero entries
                if (p_emit && (p_code != OPT_PARAMS || b != 8'd0))
                begin
                    have_val                = 1'b1;
                    val_rec.record_kind     = KIND_VALUE;
                    val_rec.option_code     = p_code;
                    val_rec.value_byte      = b;
                    val_rec.value_index     = p_idx;
                end
                p_idx  = p_idx + 8'd1;
                p_left = p_left - 8'd1;
                if (p_left == 8'd0)
                begin
                    if (p_code == OPT_MSG_TYPE)
                        p_type = p_shift[7:0];
                    // short lease option never commits
                    if (p_code == OPT_LEASE && p_idx >= 8'd4)
                    begin
                        p_lease = p_shift;
                        p_lflag = 1'b1;
                    end
                    p_shift = '0;
                    p_emit  = 1'b0;
                    p_phase = PH_CODE;
                end
            end
            default:
            begin
            end
        endcase

        if (have_val)
        begin
            val_rec.run_end = !beat.last_byte;
            records_due.push_back(val_rec);
        end
        if (beat.last_byte)
        begin
            // packet ended mid-header or mid-option; code and done states keep their status
            if (p_phase == PH_HEADER || p_phase == PH_LEN || p_phase == PH_VALUE)
                p_status = STATUS_TRUNCATED;
            sum_rec               = '0;
            sum_rec.record_kind   = KIND_SUMMARY;
            sum_rec.client_mac    = p_mac;
            sum_rec.offered_ip    = p_ip;
            sum_rec.message_type  = p_type;
            sum_rec.lease_seconds = p_lease;
            sum_rec.lease_present = p_lflag;
            sum_rec.packet_status = p_status;
            sum_rec.run_end       = 1'b1;
            records_due.push_back(sum_rec);
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("[%0t] mismatch: %s got %0h want %0h", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    task automatic check_field(input string what, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Output side: random stall, compare every accepted beat
    always @(posedge clk)
    begin : watch
        out_beat_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (records_due.size() == 0)
                    report_mismatch("record with none expected, kind",
                                    48'(out_data.record_kind), 48'(KIND_VALUE));
                else
                begin
                    want = records_due.pop_front();
                    check_field("record_kind", 48'(out_data.record_kind),
                                48'(want.record_kind));
                    check_field("option_code", 48'(out_data.option_code),
                                48'(want.option_code));
                    check_field("value_byte", 48'(out_data.value_byte),
                                48'(want.value_byte));
                    check_field("value_index", 48'(out_data.value_index),
                                48'(want.value_index));
                    check_field("client_mac", out_data.client_mac, want.client_mac);
                    check_field("offered_ip", 48'(out_data.offered_ip),
                                48'(want.offered_ip));
                    check_field("message_type", 48'(out_data.message_type),
                                48'(want.message_type));
                    check_field("lease_seconds", 48'(out_data.lease_seconds),
                                48'(want.lease_seconds));
                    check_field("lease_present", 48'(out_data.lease_present),
                                48'(want.lease_present));
                    check_field("packet_status", 48'(out_data.packet_status),
                                48'(want.packet_status));
                    check_field("run_end", 48'(out_data.run_end), 48'(want.run_end));
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < 10);
        end
    end

    // ------------------------------------------------------------------
    // Driver: works through the plan one step at a time. Next values are
    // built in locals so each output gets one nonblocking write per edge.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : drive
        plan_item_t step;
        logic       nxt_valid;
        in_beat_t   nxt_data;
        logic       nxt_we;
        logic       nxt_idx;
        logic [7:0] nxt_wdata;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= REG_HOSTNAME_MAX;
            cfg_wdata <= 8'd0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_data  = in_data;
            nxt_we    = 1'b0;
            nxt_idx   = cfg_index;
            nxt_wdata = cfg_wdata;

            // register write lands on this edge
            if (cfg_we)
            begin
                set_limit(cfg_index, cfg_wdata);
                void'(plan.pop_front());
            end
            // beat accepted on this edge
            if (in_valid && !in_stall)
            begin
                parse_byte(in_data);
                void'(plan.pop_front());
                nxt_valid = 1'b0;
            end

            if (!nxt_valid && plan.size() != 0)
            begin
                step = plan[0];
                case (step.kind)
                    ACT_BYTE:
                    begin
                        if (quiet || $urandom_range(99) >= 10)
                        begin
                            nxt_valid = 1'b1;
                            nxt_data  = step.beat;
                        end
                    end
                    ACT_HOLD:
                    begin
                        // wait for every record, then for settle_cnt to reach SETTLE
                        if (records_due.size() == 0)
                        begin
                            if (settle_cnt >= SETTLE)
                            begin
                                settle_cnt = 0;
                                void'(plan.pop_front());
                            end
                            else
                                settle_cnt = settle_cnt + 1;
                        end
                        else
                            settle_cnt = 0;
                    end
                    default:
                    begin
                        nxt_we    = 1'b1;
                        nxt_idx   = step.idx;
                        nxt_wdata = step.val;
                    end
                endcase
            end

            in_valid  <= nxt_valid;
            in_data   <= nxt_data;
            cfg_we    <= nxt_we;
            cfg_index <= nxt_idx;
            cfg_wdata <= nxt_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Packet building
    // ------------------------------------------------------------------

    task automatic start_packet(input logic [47:0] mac, input logic [31:0] ip);
        pkt.delete();
        for (int i = 0; i < HDR_LEN; i++)
        begin
            if (i >= 16 && i <= 19)
                pkt.push_back(ip[8 * (19 - i) +: 8]);
            else if (i >= 28 && i <= 33)
                pkt.push_back(mac[8 * (33 - i) +: 8]);
            else
                pkt.push_back(8'($urandom_range(255)));
        end
    endtask

    // bad_at selects a cookie byte to corrupt; -1 keeps the cookie good
    task automatic add_cookie(input int bad_at);
        logic [7:0] b;
        for (int i = 0; i < 4; i++)
        begin
            b = MAGIC_COOKIE[8 * (3 - i) +: 8];
            if (i == bad_at)
                b = b ^ 8'($urandom_range(1, 255));
            pkt.push_back(b);
        end
    endtask

    task automatic add_opt(input logic [7:0] code, input int len);
        pkt.push_back(code);
        pkt.push_back(8'(len));
        for (int i = 0; i < len; i++)
        begin
            if (code == OPT_PARAMS && $urandom_range(3) == 0)
                pkt.push_back(8'd0);
            else
                pkt.push_back(8'($urandom_range(255)));
        end
    endtask

    // cut > 0 ends the packet early; hold_at >= 0 pauses before that byte
    task automatic send_packet(input int cut, input int hold_at);
        int         n;
        plan_item_t step;
        n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at)
            begin
                step      = '0;
                step.kind = ACT_HOLD;
                plan.push_back(step);
            end
            step                = '0;
            step.kind           = ACT_BYTE;
            step.beat.data_byte = pkt[i];
            step.beat.last_byte = (i == n - 1);
            plan.push_back(step);
        end
        sent_bytes = sent_bytes + n;
    endtask

    task automatic plan_config(input logic idx, input logic [7:0] val);
        plan_item_t step;
        step      = '0;
        step.kind = ACT_HOLD;
        plan.push_back(step);
        step.kind = ACT_CFG;
        step.idx  = idx;
        step.val  = val;
        plan.push_back(step);
        if (idx == REG_HOSTNAME_MAX)
            gen_host = val;
        else
            gen_vend = val;
    endtask

    // Length aimed at a limit now and then, sometimes empty or any size, else short
    function automatic int pick_len(input logic [7:0] limit);
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 0;
        else if (r == 1)
            return int'(limit);
        else if (r == 2)
            return (limit == 8'd255) ? 255 : int'(limit) + 1;
        else if (r == 3)
            return $urandom_range(255);
        return $urandom_range(1, 8);
    endfunction

    function automatic logic [7:0] pick_limit();
        int r;
        r = $urandom_range(3);
        if (r == 0)
            return 8'd1;
        else if (r == 1)
            return 8'd255;
        return 8'($urandom_range(1, 40));
    endfunction

    task automatic random_packet();
        logic [63:0] w;
        logic [47:0] mac;
        logic [31:0] ip;
        int          nopt;
        int          cut;
        int          hold_at;
        w   = {$urandom, $urandom};
        mac = w[47:0];
        ip  = $urandom;
        if ($urandom_range(19) == 0)
        begin
            mac = '1;
            ip  = '0;
        end
        start_packet(mac, ip);
        if ($urandom_range(99) < 6)
        begin
            // broken cookie, then bytes the parser must ignore
            add_cookie($urandom_range(3));
            for (int i = $urandom_range(3); i > 0; i--)
                pkt.push_back(8'($urandom_range(255)));
        end
        else
        begin
            add_cookie(-1);
            nopt = $urandom_range(7);
            for (int k = 0; k < nopt; k++)
            begin
                case ($urandom_range(8))
                    0: pkt.push_back(OPT_PAD);
                    1: add_opt(OPT_HOSTNAME, pick_len(gen_host));
                    2: add_opt(OPT_LEASE, $urandom_range(6));
                    3: add_opt(OPT_MSG_TYPE, ($urandom_range(4) == 0) ? $urandom_range(2) : 1);
                    4: add_opt(OPT_PARAMS, $urandom_range(10));
                    5: add_opt(OPT_VENDOR, pick_len(gen_vend));
                    6: add_opt(OPT_SEARCH, $urandom_range(6));
                    default: add_opt(8'($urandom_range(1, 254)), $urandom_range(4));
                endcase
            end
            if ($urandom_range(9) < 7)
            begin
                pkt.push_back(OPT_END);
                for (int i = $urandom_range(3); i > 0; i--)
                    pkt.push_back(8'($urandom_range(255)));
            end
        end
        cut     = ($urandom_range(99) < 12) ? $urandom_range(1, pkt.size()) : 0;
        hold_at = ($urandom_range(99) < 4) ? $urandom_range(pkt.size() - 1) : -1;
        send_packet(cut, hold_at);
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin
        int npkt;

        // tight limits keep the directed packets short
        plan_config(REG_HOSTNAME_MAX, 8'd3);
        plan_config(REG_VENDOR_MAX, 8'd2);

        // all-ones header fields, every tracked option, limits exactly met,
        // parameter list that may hold zeros, short lease, empty and oversized options,
        // repeats where the last one wins, pause mid-packet
        start_packet('1, '1);
        add_cookie(-1);
        add_opt(OPT_MSG_TYPE, 1);
        add_opt(OPT_LEASE, 4);
        pkt.push_back(OPT_PAD);
        add_opt(OPT_PARAMS, 6);
        add_opt(OPT_HOSTNAME, int'(gen_host));
        add_opt(OPT_VENDOR, int'(gen_vend));
        add_opt(OPT_VENDOR, int'(gen_vend) + 1);
        add_opt(OPT_HOSTNAME, 0);
        add_opt(OPT_VENDOR, 0);
        add_opt(OPT_LEASE, 3);
        add_opt(OPT_MSG_TYPE, 0);
        add_opt(OPT_LEASE, 6);
        add_opt(OPT_MSG_TYPE, 2);
        add_opt(OPT_SEARCH, 3);
        add_opt(OPT_PARAMS, 0);
        add_opt(8'd200, 2);
        pkt.push_back(OPT_END);
        pkt.push_back(8'hA5);
        pkt.push_back(8'h5A);
        send_packet(0, 250);

        // hostname over the limit discards the rest
        start_packet(48'h0123_4567_89AB, 32'hC0A8_0001);
        add_cookie(-1);
        add_opt(OPT_MSG_TYPE, 1);
        add_opt(OPT_HOSTNAME, int'(gen_host) + 1);
        add_opt(OPT_LEASE, 4);
        send_packet(0, -1);

        // bad cookie at a random position, then bytes the parser must ignore
        start_packet(48'hFEDC_BA98_7654, 32'h0A00_0002);
        add_cookie($urandom_range(3));
        pkt.push_back(OPT_MSG_TYPE);
        pkt.push_back(8'd1);
        send_packet(0, -1);

        // truncation after a single header byte
        start_packet('1, 32'h1234_5678);
        send_packet(1, -1);

        // zero header fields; last byte inside a lease value: not committed
        start_packet('0, '0);
        add_cookie(-1);
        add_opt(OPT_SEARCH, 2);
        add_opt(OPT_LEASE, 4);
        send_packet(HDR_LEN + 12, -1);

        // random packets, limits changed every other packet
        npkt = 0;
        while (sent_bytes < ITEM_BUDGET)
        begin
            if (npkt % 2 == 1)
            begin
                plan_config(REG_HOSTNAME_MAX, pick_limit());
                plan_config(REG_VENDOR_MAX, pick_limit());
            end
            random_packet();
            npkt = npkt + 1;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (plan.size() != 0)
            @(posedge clk);
        while (records_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (records_due.size() != 0)
            report_mismatch("records never delivered", 48'(records_due.size()), 48'(0));
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
design/dosp_pkg.sv
design/dosp_parser.sv
design/dosp_out_fifo.sv
design/dhcp_option_stream_parser.sv
test/tb_top.sv
